FILE: src/window_below_average_tracker_assert.svh
// assertion macros shared by the tracker modules
`ifndef WINDOW_BELOW_AVERAGE_TRACKER_ASSERT_SVH
`define WINDOW_BELOW_AVERAGE_TRACKER_ASSERT_SVH

// same-cycle implication, off during reset
`define WBAT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define WBAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/wbat_pkg.sv
package wbat_pkg;

  localparam int WINDOW_SIZE_DEF = 1024;
  localparam int SAMPLE_BITS_DEF = 12;

  localparam int FUNC_W   = 2;
  localparam int RAW_W    = 12;
  localparam int PEAK_W   = 11;
  localparam int BELOW_W  = 12;
  localparam int AVG_W    = 12;
  localparam int CNT_OUT_W = 11;

  localparam logic [PEAK_W-1:0] LED_FS_RESET = 11'd20;

  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_AVG    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COUNT  = 2'd2;

  typedef struct packed {
    logic accept;
    logic smp_upd;
    logic div_step;
    logic walk_step;
    logic out_load;
  } wbat_cmd_t;

  typedef struct packed {
    logic div_done;
    logic walk_done;
  } wbat_sts_t;

endpackage

FILE: src/wbat_in_if.sv
interface wbat_in_if
  import wbat_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [RAW_W-1:0]  sample;

  modport source (output valid, output func, output sample, input ready);
  modport sink (input valid, input func, input sample, output ready);
endinterface

FILE: src/wbat_out_if.sv
interface wbat_out_if
  import wbat_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [PEAK_W-1:0]    peak_count;
  logic [PEAK_W-1:0]    led_level;
  logic [AVG_W-1:0]     average_value;
  logic [CNT_OUT_W-1:0] below_count;

  modport source (output valid, output peak_count, output led_level,
                  output average_value, output below_count, input ready);
  modport sink (input valid, input peak_count, input led_level,
                input average_value, input below_count, output ready);
endinterface

FILE: src/wbat_cfg_if.sv
interface wbat_cfg_if
  import wbat_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [PEAK_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/wbat_ctrl.sv
`include "window_below_average_tracker_assert.svh"

module wbat_ctrl
  import wbat_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [FUNC_W-1:0] in_func,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  wbat_sts_t         sts,
  output wbat_cmd_t         cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SMP  = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_WALK = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;
  logic   acc;

  assign in_ready  = (state_r == ST_IDLE);
  assign acc       = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          cmd.accept = 1'b1;
          case (in_func)
            FUNC_SAMPLE: state_nxt = ST_SMP;
            FUNC_AVG:    state_nxt = ST_DIV;
            FUNC_COUNT:  state_nxt = ST_WALK;
            default:     state_nxt = ST_FIN;
          endcase
        end
      end
      ST_SMP: begin
        cmd.smp_upd = 1'b1;
        state_nxt   = ST_FIN;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_WALK: begin
        if (sts.walk_done) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `WBAT_ASSERT_NOW(a_load_free, clk, rst_n, cmd.out_load, !out_valid_r || out_ready, "result loaded over a waiting word")
  `WBAT_ASSERT_NOW(a_cmd_excl, clk, rst_n, 1'b1, $onehot0(cmd), "more than one datapath command")
  `WBAT_ASSERT_NEXT(a_smp_path, clk, rst_n, acc && in_func == FUNC_SAMPLE, cmd.smp_upd, "sample word not updated next cycle")

endmodule

FILE: src/wbat_dp.sv
`include "window_below_average_tracker_assert.svh"

module wbat_dp
  import wbat_pkg::*;
#(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wbat_cmd_t            cmd,
  output wbat_sts_t            sts,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [RAW_W-1:0]     in_sample,
  input  logic                 cfg_wr,
  input  logic [PEAK_W-1:0]    cfg_data,
  output logic [PEAK_W-1:0]    out_peak_count,
  output logic [PEAK_W-1:0]    out_led_level,
  output logic [AVG_W-1:0]     out_average_value,
  output logic [CNT_OUT_W-1:0] out_below_count
);

  localparam int IDX_W  = $clog2(WINDOW_SIZE);
  localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
  localparam int SUM_W  = SAMPLE_BITS + IDX_W;
  localparam int PROD_W = SAMPLE_BITS + CNT_W;
  // reciprocal of the window size, exact for every sum below 2**SUM_W
  localparam int RCP_SH = SUM_W + IDX_W;
  localparam int RCP_W  = SUM_W + 1;
  localparam int QPR_W  = SUM_W + RCP_W;
  localparam logic [63:0] RCP_FULL =
    ((64'd1 << RCP_SH) + 64'(WINDOW_SIZE) - 64'd1) / 64'(WINDOW_SIZE);
  localparam logic [RCP_W-1:0] RCP_K = RCP_FULL[RCP_W-1:0];

  logic [SAMPLE_BITS-1:0] mem [WINDOW_SIZE];
  logic [SAMPLE_BITS-1:0] rd_q;

  logic [FUNC_W-1:0]      func_r;
  logic [SAMPLE_BITS-1:0] s_r;
  logic [IDX_W-1:0]       pos_r;
  logic                   filled_r;
  logic [SUM_W-1:0]       sum_r;
  logic [BELOW_W-1:0]     below_r;
  logic [PEAK_W-1:0]      peak_r;
  logic [PEAK_W-1:0]      fs_r;

  logic [AVG_W-1:0]       avg_r;
  logic                   avg_done_r;

  logic [CNT_W-1:0]       idx_r;
  logic                   pend_r;
  logic [CNT_W-1:0]       cnt_r;

  logic [CNT_W-1:0]       n_fill;
  logic                   issue;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;

  logic [SAMPLE_BITS-1:0] old_sel;
  logic [PROD_W-1:0]      sum_calc;
  logic [SUM_W-1:0]       sum_nxt;
  logic [CNT_W-1:0]       div_sel;
  logic [PROD_W-1:0]      prod_old;
  logic [PROD_W-1:0]      prod_new;
  logic                   dec;
  logic                   inc;
  logic                   old_below;
  logic [BELOW_W-1:0]     below_nxt;
  logic [PEAK_W-1:0]      peak_nxt;
  logic [PEAK_W-1:0]      led;

  logic [QPR_W-1:0]       avg_prod;

  // entries written so far
  assign n_fill  = filled_r ? CNT_W'(WINDOW_SIZE) : CNT_W'(pos_r);
  assign issue   = cmd.walk_step && (idx_r < n_fill);
  assign rd_en   = cmd.accept || issue;
  assign rd_addr = cmd.walk_step ? idx_r[IDX_W-1:0] : pos_r;

  always_ff @(posedge clk) begin
    if (cmd.smp_upd) begin
      mem[pos_r] <= s_r;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // rd_q * window is shared by eviction and the count walk
  assign prod_old  = PROD_W'(rd_q) * PROD_W'(WINDOW_SIZE);
  assign old_below = prod_old < PROD_W'(sum_r);

  assign old_sel  = filled_r ? rd_q : '0;
  assign sum_calc = PROD_W'(sum_r) + PROD_W'(s_r) - PROD_W'(old_sel);
  assign sum_nxt  = SUM_W'(sum_calc);
  assign div_sel  = filled_r ? CNT_W'(WINDOW_SIZE) : CNT_W'(pos_r) + CNT_W'(1);
  assign prod_new = PROD_W'(s_r) * PROD_W'(div_sel);
  assign dec      = filled_r && old_below;
  assign inc      = prod_new < PROD_W'(sum_nxt);

  assign below_nxt = below_r + BELOW_W'(inc) - BELOW_W'(dec);

  always_comb begin
    peak_nxt = peak_r;
    if (!below_nxt[BELOW_W-1] && (below_nxt[PEAK_W-1:0] > peak_r)) begin
      peak_nxt = below_nxt[PEAK_W-1:0];
    end
    if (below_nxt == '0) begin
      peak_nxt = '0;
    end
  end

  // sum / window as a multiply by the scaled reciprocal and a shift
  assign avg_prod = QPR_W'(sum_r) * QPR_W'(RCP_K);

  assign led = (peak_r < fs_r) ? peak_r : fs_r;

  assign sts.div_done  = avg_done_r;
  assign sts.walk_done = (idx_r == n_fill) && !pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      filled_r   <= 1'b0;
      sum_r      <= '0;
      below_r    <= '0;
      peak_r     <= '0;
      fs_r       <= LED_FS_RESET;
      idx_r      <= '0;
      pend_r     <= 1'b0;
      avg_done_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        fs_r <= cfg_data;
      end
      if (cmd.accept) begin
        idx_r      <= '0;
        pend_r     <= 1'b0;
        avg_done_r <= 1'b0;
      end
      if (cmd.smp_upd) begin
        sum_r   <= sum_nxt;
        below_r <= below_nxt;
        peak_r  <= peak_nxt;
        if (pos_r == IDX_W'(WINDOW_SIZE - 1)) begin
          pos_r    <= '0;
          filled_r <= 1'b1;
        end else begin
          pos_r <= pos_r + IDX_W'(1);
        end
      end
      if (cmd.div_step) begin
        avg_done_r <= 1'b1;
      end
      if (cmd.walk_step) begin
        pend_r <= issue;
        if (issue) begin
          idx_r <= idx_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r <= in_func;
      s_r    <= SAMPLE_BITS'(in_sample);
      cnt_r  <= '0;
    end
    if (cmd.div_step) begin
      avg_r <= avg_prod[RCP_SH +: AVG_W];
    end
    if (cmd.walk_step && pend_r && old_below) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (cmd.out_load) begin
      out_peak_count    <= peak_r;
      out_led_level     <= led;
      out_average_value <= (func_r == FUNC_AVG) ? avg_r : '0;
      out_below_count   <= (func_r == FUNC_COUNT) ? CNT_OUT_W'(cnt_r) : '0;
    end
  end

  `WBAT_ASSERT_NEXT(a_pos_wrap, clk, rst_n, cmd.smp_upd && pos_r == IDX_W'(WINDOW_SIZE - 1), filled_r && pos_r == '0, "write position did not wrap into filled")
  `WBAT_ASSERT_NOW(a_peak_clear, clk, rst_n, peak_r != '0, below_r != '0, "peak held while counter is zero")
  `WBAT_ASSERT_NOW(a_walk_bound, clk, rst_n, 1'b1, idx_r <= n_fill, "count walk ran past filled entries")

endmodule

FILE: src/window_below_average_tracker.sv
// channel  dir  handshake       payload
// in_ch    in   valid / ready   func, sample
// out_ch   out  valid / ready   peak_count, led_level, average_value, below_count
// cfg_ch   in   valid / ready   data (led full scale)
//
// sample tick: accept with store read, then update and store write, then result load
// average query: one multiply by the reciprocal of the window size into a register
// count query: one store read per filled entry, none while the store is empty
// reset is synchronous; the sample store is not cleared and only filled entries are used
// one result word waits in the output register; one item may be accepted meanwhile
module window_below_average_tracker
  import wbat_pkg::*;
#(
  parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  wbat_in_if.sink    in_ch,
  wbat_out_if.source out_ch,
  wbat_cfg_if.sink   cfg_ch
);

  wbat_cmd_t cmd;
  wbat_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  wbat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_func   (in_ch.func),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wbat_dp #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_func           (in_ch.func),
    .in_sample         (in_ch.sample),
    .cfg_wr            (cfg_ch.valid),
    .cfg_data          (cfg_ch.data),
    .out_peak_count    (out_ch.peak_count),
    .out_led_level     (out_ch.led_level),
    .out_average_value (out_ch.average_value),
    .out_below_count   (out_ch.below_count)
  );

endmodule
